/* rtl/lspe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lspe_pkg;

   localparam int SENSOR_COUNT = 5;
   localparam int FULL_SCALE = 1000;
   localparam int QUO_BITS = 11;      // quotient bits per divide, saturates at 2047
   localparam int LEVEL_BITS = 10;
   localparam int LOST_BITS = 11;
   localparam int ERROR_BITS = 12;
   localparam int WSUM_BITS = 23;     // |weighted sum| <= 3,000,000
   localparam int NSUM_BITS = 13;     // sum of clamped levels <= 5000
   localparam int OP_BITS = 2;
   localparam int RSP_DATA_BITS = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [OP_BITS-1:0] op_type;
   typedef logic [1:0] reg_index_type;

   localparam op_type OP_CLEAR = 2'd0;
   localparam op_type OP_CALIBRATE = 2'd1;
   localparam op_type OP_MEASURE = 2'd2;

   localparam reg_index_type REG_ACTIVE_LEVEL = 2'd0;
   localparam reg_index_type REG_BRANCH_LEVEL = 2'd1;
   localparam reg_index_type REG_WHITE_LEVEL = 2'd2;
   localparam reg_index_type REG_LOST_ERROR = 2'd3;

   localparam logic [LEVEL_BITS-1:0] ACTIVE_LEVEL_RESET = 10'd200;
   localparam logic [LEVEL_BITS-1:0] BRANCH_LEVEL_RESET = 10'd300;
   localparam logic [LEVEL_BITS-1:0] WHITE_LEVEL_RESET = 10'd100;
   localparam logic [LOST_BITS-1:0] LOST_ERROR_RESET = 11'd1500;

   typedef logic signed [ERROR_BITS-1:0] weight_type;

   // position weights, left to right
   localparam weight_type SENSOR_WEIGHT [SENSOR_COUNT] = '{
      -12'sd2000, -12'sd1000, 12'sd0, 12'sd1000, 12'sd2000
   };

endpackage

`default_nettype wire

/* rtl/line_sensor_position_estimator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Five-channel line sensor position estimator. Op 0 clears the per-sensor
// calibration bounds, op 1 widens them, op 2 scales each sample to 0..1000
// against its bounds and returns the weighted centroid (-2000..2000) with the
// line-lost, station-mark, branch and all-white flags; ops other than 2 return zeros.
// A calibration op passes through S_DONE into the output register. A measure
// uses one shared restoring divider that produces 11 quotient bits, one per cycle;
// it runs for the five scalings, then for the centroid unless no sensor is active,
// each run framed by S_LOAD or S_CLOAD, S_CHECK and S_POST; a scaling whose
// quotient is out of range skips the divide steps. req_tready is low while an
// item is in work; a finished result waits in the output register.
module line_sensor_position_estimator #(
   parameter int SAMPLE_BITS = 12,
   localparam int ReqDataBits = ((lspe_pkg::SENSOR_COUNT * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // sample_0 .. sample_4 (SAMPLE_BITS each), prev_error_positive, zero fill
   input  wire logic [ReqDataBits-1:0]              req_tdata,
   // op
   input  wire logic [lspe_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // line_error[11:0], line_lost, station_mark, branch_seen, all_white
   output logic [lspe_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lspe_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [lspe_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lspe_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);
   import lspe_pkg::*;

   localparam int NumBits = (SAMPLE_BITS + 10 > WSUM_BITS - 1) ? SAMPLE_BITS + 10
                                                              : WSUM_BITS - 1;
   localparam int DenBits = (SAMPLE_BITS > NSUM_BITS) ? SAMPLE_BITS : NSUM_BITS;
   localparam int IdxBits = $clog2(SENSOR_COUNT);
   localparam int CntBits = $clog2(QUO_BITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;
   localparam logic [2:0] S_CLOAD = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(SENSOR_COUNT - 1);
   localparam logic [CntBits-1:0] LastStep = CntBits'(QUO_BITS - 1);

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // control state
   logic [2:0]            state_ff, state_in;
   logic [IdxBits-1:0]    idx_ff, idx_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  centroid_ff, centroid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            cal_low_ff [SENSOR_COUNT];
   sample_type            cal_low_in [SENSOR_COUNT];
   sample_type            cal_high_ff [SENSOR_COUNT];
   sample_type            cal_high_in [SENSOR_COUNT];
   logic [LEVEL_BITS-1:0] active_level_ff, branch_level_ff, white_level_ff;
   logic [LOST_BITS-1:0]  lost_error_ff;

   // datapath
   op_type                op_ff, op_in;
   logic                  prev_pos_ff, prev_pos_in;
   sample_type            samp_ff [SENSOR_COUNT];
   sample_type            samp_in [SENSOR_COUNT];
   logic [NumBits-1:0]    dvd_ff, dvd_in;
   logic [DenBits-1:0]    dvs_ff, dvs_in;
   logic [DenBits-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0]   shq_ff, shq_in;
   logic                  neg_ff, neg_in;
   logic signed [WSUM_BITS-1:0] wsum_ff, wsum_in;
   logic [NSUM_BITS-1:0]  nsum_ff, nsum_in;
   logic                  any_active_ff, any_active_in;
   logic [2:0]            dark_cnt_ff, dark_cnt_in;
   logic                  outer_ff, outer_in;
   logic                  white_all_ff, white_all_in;
   logic                  mid_all_ff, mid_all_in;
   logic                  lost_ff, lost_in;
   logic [ERROR_BITS-1:0] err_ff, err_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;

   // unpacked request
   sample_type            req_sample [SENSOR_COUNT];
   logic                  req_prev_pos;
   logic                  req_xfer;

   // scaling setup
   sample_type                  cur_s, cur_lo, cur_hi;
   logic signed [SAMPLE_BITS:0] diff, span;
   sample_type                  diff_mag, span_mag;
   logic [NumBits-1:0]          num_mag;
   logic [SAMPLE_BITS+2:0]      s_times5, hi_times4;

   // divider step
   logic [DenBits:0]      trial;
   logic                  trial_ge;
   logic                  range_over;

   // accumulation
   logic                  v_neg;
   logic [LEVEL_BITS-1:0] clamped;
   logic signed [WSUM_BITS-1:0] prod;
   logic [WSUM_BITS-2:0]  wsum_mag;
   logic [ERROR_BITS-1:0] q_ext;

   logic                  csr_write;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         req_sample[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end
   assign req_prev_pos = req_tdata[SENSOR_COUNT*SAMPLE_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = out_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_ACTIVE_LEVEL: csr_prdata = CSR_DATA_BITS'(active_level_ff);
         REG_BRANCH_LEVEL: csr_prdata = CSR_DATA_BITS'(branch_level_ff);
         REG_WHITE_LEVEL:  csr_prdata = CSR_DATA_BITS'(white_level_ff);
         REG_LOST_ERROR:   csr_prdata = CSR_DATA_BITS'(lost_error_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // scaling setup for the current sensor
   assign cur_s = samp_ff[idx_ff];
   assign cur_lo = cal_low_ff[idx_ff];
   assign cur_hi = cal_high_ff[idx_ff];
   assign diff = $signed({1'b0, cur_s}) - $signed({1'b0, cur_lo});
   assign span = $signed({1'b0, cur_hi}) - $signed({1'b0, cur_lo});
   assign diff_mag = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
   assign span_mag = span[SAMPLE_BITS] ? SAMPLE_BITS'(-span) : span[SAMPLE_BITS-1:0];
   assign num_mag = NumBits'(diff_mag) * NumBits'(FULL_SCALE);
   // s > floor(4*high/5) is the same test as 5*s > 4*high
   assign s_times5 = {2'b00, cur_s, 1'b0} + {3'b000, cur_s} + {2'b00, cur_s, 1'b0};
   assign hi_times4 = {1'b0, cur_hi, 2'b00};

   // restoring divider, one quotient bit per cycle
   assign range_over = {QUO_BITS'(0), dvd_ff[NumBits-1:QUO_BITS]} >= NumBits'(dvs_ff);
   assign trial = {rem_ff, shq_ff[QUO_BITS-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};

   // per-sensor accumulation
   assign v_neg = neg_ff && (shq_ff != '0);
   always_comb begin
      if (v_neg) begin
         clamped = '0;
      end else if (shq_ff > QUO_BITS'(FULL_SCALE)) begin
         clamped = LEVEL_BITS'(FULL_SCALE);
      end else begin
         clamped = shq_ff[LEVEL_BITS-1:0];
      end
   end
   assign prod = $signed({1'b0, clamped}) * SENSOR_WEIGHT[idx_ff];
   assign wsum_mag = wsum_ff[WSUM_BITS-1] ? (WSUM_BITS-1)'(-wsum_ff)
                                          : wsum_ff[WSUM_BITS-2:0];
   assign q_ext = {1'b0, shq_ff};

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      centroid_in = centroid_ff;
      rsp_valid_in = rsp_valid_ff;
      cal_low_in = cal_low_ff;
      cal_high_in = cal_high_ff;
      op_in = op_ff;
      prev_pos_in = prev_pos_ff;
      samp_in = samp_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      shq_in = shq_ff;
      neg_in = neg_ff;
      wsum_in = wsum_ff;
      nsum_in = nsum_ff;
      any_active_in = any_active_ff;
      dark_cnt_in = dark_cnt_ff;
      outer_in = outer_ff;
      white_all_in = white_all_ff;
      mid_all_in = mid_all_ff;
      lost_in = lost_ff;
      err_in = err_ff;
      out_data_in = out_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in = req_tuser;
               prev_pos_in = req_prev_pos;
               samp_in = req_sample;
               idx_in = '0;
               centroid_in = 1'b0;
               wsum_in = '0;
               nsum_in = '0;
               any_active_in = 1'b0;
               dark_cnt_in = '0;
               outer_in = 1'b0;
               white_all_in = 1'b1;
               mid_all_in = 1'b1;
               lost_in = 1'b0;
               err_in = '0;
               state_in = S_DONE;
               unique case (req_tuser)
                  OP_CLEAR: begin
                     for (int i = 0; i < SENSOR_COUNT; i++) begin
                        cal_low_in[i] = '1;
                        cal_high_in[i] = '0;
                     end
                  end
                  OP_CALIBRATE: begin
                     for (int i = 0; i < SENSOR_COUNT; i++) begin
                        if (req_sample[i] < cal_low_ff[i]) begin
                           cal_low_in[i] = req_sample[i];
                        end
                        if (req_sample[i] > cal_high_ff[i]) begin
                           cal_high_in[i] = req_sample[i];
                        end
                     end
                  end
                  OP_MEASURE: begin
                     state_in = S_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD: begin
            dvd_in = num_mag;
            dvs_in = (span_mag == '0) ? DenBits'(1) : DenBits'(span_mag);
            neg_in = diff[SAMPLE_BITS] ^ span[SAMPLE_BITS];
            if ((idx_ff != '0) && (idx_ff != LastIdx) && !(s_times5 > hi_times4)) begin
               mid_all_in = 1'b0;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (range_over) begin
               shq_in = '1;
               state_in = S_POST;
            end else begin
               rem_in = DenBits'(dvd_ff >> QUO_BITS);
               shq_in = dvd_ff[QUO_BITS-1:0];
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = trial_ge ? DenBits'(trial - {1'b0, dvs_ff}) : trial[DenBits-1:0];
            shq_in = {shq_ff[QUO_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (centroid_ff) begin
               err_in = neg_ff ? ERROR_BITS'(-q_ext) : q_ext;
               state_in = S_DONE;
            end else begin
               if (clamped > active_level_ff) begin
                  wsum_in = wsum_ff + prod;
                  nsum_in = nsum_ff + NSUM_BITS'(clamped);
                  any_active_in = 1'b1;
               end
               if (!v_neg && (shq_ff > {1'b0, branch_level_ff})) begin
                  dark_cnt_in = dark_cnt_ff + 1'b1;
                  if ((idx_ff == '0) || (idx_ff == LastIdx)) begin
                     outer_in = 1'b1;
                  end
               end
               if (!(v_neg || (shq_ff < {1'b0, white_level_ff}))) begin
                  white_all_in = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff == LastIdx) ? S_CLOAD : S_LOAD;
            end
         end
         S_CLOAD: begin
            if (!any_active_ff) begin
               lost_in = 1'b1;
               err_in = prev_pos_ff ? {1'b0, lost_error_ff}
                                    : ERROR_BITS'(-{1'b0, lost_error_ff});
               state_in = S_DONE;
            end else begin
               dvd_in = NumBits'(wsum_mag);
               dvs_in = DenBits'(nsum_ff);
               neg_in = wsum_ff[WSUM_BITS-1];
               centroid_in = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (op_ff == OP_MEASURE) begin
                  out_data_in = {white_all_ff, (dark_cnt_ff >= 3'd3) && outer_ff,
                                 mid_all_ff, lost_ff, err_ff};
               end else begin
                  out_data_in = '0;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         cnt_ff <= '0;
         centroid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            cal_low_ff[i] <= '1;
            cal_high_ff[i] <= '0;
         end
         active_level_ff <= ACTIVE_LEVEL_RESET;
         branch_level_ff <= BRANCH_LEVEL_RESET;
         white_level_ff <= WHITE_LEVEL_RESET;
         lost_error_ff <= LOST_ERROR_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         centroid_ff <= centroid_in;
         rsp_valid_ff <= rsp_valid_in;
         cal_low_ff <= cal_low_in;
         cal_high_ff <= cal_high_in;
         if (csr_write) begin
            unique case (reg_index_type'(csr_paddr[3:2]))
               REG_ACTIVE_LEVEL: active_level_ff <= csr_pwdata[LEVEL_BITS-1:0];
               REG_BRANCH_LEVEL: branch_level_ff <= csr_pwdata[LEVEL_BITS-1:0];
               REG_WHITE_LEVEL:  white_level_ff <= csr_pwdata[LEVEL_BITS-1:0];
               REG_LOST_ERROR:   lost_error_ff <= csr_pwdata[LOST_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      prev_pos_ff <= prev_pos_in;
      samp_ff <= samp_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      shq_ff <= shq_in;
      neg_ff <= neg_in;
      wsum_ff <= wsum_in;
      nsum_ff <= nsum_in;
      any_active_ff <= any_active_in;
      dark_cnt_ff <= dark_cnt_in;
      outer_ff <= outer_in;
      white_all_ff <= white_all_in;
      mid_all_ff <= mid_all_in;
      lost_ff <= lost_in;
      err_ff <= err_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

/* rtl/lspe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lspe_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [lspe_pkg::OP_BITS-1:0]        req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [lspe_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import lspe_pkg::*;

   // nothing is pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // one item at a time: a transfer takes the block busy
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // calibration and unused ops return an all-zero result
   a_cal_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_MEASURE) && !rsp_tvalid
      |=> ##1 rsp_tvalid && (rsp_tdata == '0))
      else $error("calibration op result missing or nonzero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

endmodule

bind line_sensor_position_estimator lspe_checker u_lspe_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lspe_pkg::*;

   localparam int SampleBits = 12;
   localparam int SampleMax = (1 << SampleBits) - 1;
   localparam int ReqBits = ((SENSOR_COUNT * SampleBits + 1 + 7) / 8) * 8;
   // allow for the slowest measure plus long sender gaps and receiver stalls,
   // then leave a wide margin
   localparam int QuietLimit = 5000;
   localparam int DrainCycles = 100;
   localparam op_type OP_UNUSED = 2'd3;

   typedef logic [SampleBits-1:0] sample_type;
   typedef logic [SENSOR_COUNT-1:0][SampleBits-1:0] frame_type;

   // same bit order as rsp_tdata: line_error in the low bits
   typedef struct packed {
      logic all_white;
      logic branch_seen;
      logic station_mark;
      logic line_lost;
      logic [ERROR_BITS-1:0] line_error;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqBits-1:0] req_tdata = '0;
   op_type req_tuser = OP_CLEAR;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [LEVEL_BITS-1:0] active_level_q, branch_level_q, white_level_q;
   logic [LOST_BITS-1:0] lost_error_q;
   sample_type cal_low [SENSOR_COUNT];
   sample_type cal_high [SENSOR_COUNT];

   line_result_type expected_lines [$];
   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   line_sensor_position_estimator #(
      .SAMPLE_BITS(SampleBits)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void clear_bounds();
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         cal_low[i] = '1;
         cal_high[i] = '0;
      end
   endfunction

   // Updates the calibration bounds and returns the result of one item.
   function automatic line_result_type estimate_line(input op_type op, input frame_type frame,
                                                     input logic prev_pos);
      line_result_type r;
      longint num, den, lvl, clamped, wsum, nsum, err;
      int active_cnt, dark_cnt, white_cnt, mid_cnt;
      bit outer;
      r = '0;
      wsum = 0;
      nsum = 0;
      active_cnt = 0;
      dark_cnt = 0;
      white_cnt = 0;
      mid_cnt = 0;
      outer = 1'b0;
      case (op)
         OP_CLEAR: clear_bounds();
         OP_CALIBRATE: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               if (frame[i] < cal_low[i]) cal_low[i] = frame[i];
               if (frame[i] > cal_high[i]) cal_high[i] = frame[i];
            end
         end
         OP_MEASURE: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               num = (longint'(frame[i]) - longint'(cal_low[i])) * FULL_SCALE;
               den = longint'(cal_high[i]) - longint'(cal_low[i]);
               if (den == 0) den = 1;
               lvl = num / den;
               clamped = (lvl < 0) ? 0 : ((lvl > FULL_SCALE) ? FULL_SCALE : lvl);
               if (clamped > longint'(active_level_q)) begin
                  wsum += clamped * (longint'(i) - 2) * 1000;
                  nsum += clamped;
                  active_cnt++;
               end
               // branch and white use the unclamped level
               if (lvl > longint'(branch_level_q)) begin
                  dark_cnt++;
                  if (i == 0 || i == SENSOR_COUNT - 1) outer = 1'b1;
               end
               if (lvl < longint'(white_level_q)) white_cnt++;
               if (i >= 1 && i <= 3 &&
                   longint'(frame[i]) > (longint'(cal_high[i]) * 4) / 5) mid_cnt++;
            end
            if (active_cnt == 0 || nsum == 0)
               err = prev_pos ? longint'(lost_error_q) : -longint'(lost_error_q);
            else
               err = wsum / nsum;
            r.line_error = err[ERROR_BITS-1:0];
            r.line_lost = (active_cnt == 0);
            r.station_mark = (mid_cnt >= 3);
            r.branch_seen = (dark_cnt >= 3) && outer;
            r.all_white = (white_cnt >= SENSOR_COUNT);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input op_type op, input frame_type frame, input logic prev_pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, prev_pos, frame};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_lines.push_back(estimate_line(op, frame, prev_pos));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_ACTIVE_LEVEL: active_level_q = value[LEVEL_BITS-1:0];
         REG_BRANCH_LEVEL: branch_level_q = value[LEVEL_BITS-1:0];
         REG_WHITE_LEVEL: white_level_q = value[LEVEL_BITS-1:0];
         REG_LOST_ERROR: lost_error_q = value[LOST_BITS-1:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_writes++;
   endtask

   task automatic set_levels(input int active, input int branch, input int white,
                             input int lost);
      write_csr(REG_ACTIVE_LEVEL, active);
      write_csr(REG_BRANCH_LEVEL, branch);
      write_csr(REG_WHITE_LEVEL, white);
      write_csr(REG_LOST_ERROR, lost);
   endtask

   function automatic frame_type random_frame(input int lo, input int hi);
      frame_type f;
      for (int i = 0; i < SENSOR_COUNT; i++) f[i] = sample_type'($urandom_range(hi, lo));
      return f;
   endfunction

   // Mostly a dark band over neighboring sensors on a light floor, judged
   // against the current bounds; otherwise a per-sensor mix.
   function automatic frame_type random_measure();
      frame_type f;
      int lo, hi, tmp, p, w, kind;
      bit on_band;
      p = $urandom_range(4);
      w = $urandom_range(2);
      on_band = ($urandom_range(99) < 60);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         lo = int'(cal_low[i]);
         hi = int'(cal_high[i]);
         if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         if (on_band) kind = (i >= p && i <= p + w) ? 1 : 0;
         else kind = $urandom_range(3);
         case (kind)
            0: f[i] = sample_type'(lo + $urandom_range((hi - lo) / 4));
            1: f[i] = sample_type'(hi - $urandom_range((hi - lo) / 4));
            2: f[i] = sample_type'($urandom_range(hi, lo));
            default: f[i] = sample_type'($urandom_range(SampleMax));
         endcase
      end
      return f;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      line_result_type want, got;
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_lines.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual 0x%h", $time, got);
            mismatches++;
         end else begin
            want = expected_lines.pop_front();
            check_field("line_error", int'($signed(want.line_error)),
                        int'($signed(got.line_error)));
            check_field("line_lost", int'(want.line_lost), int'(got.line_lost));
            check_field("station_mark", int'(want.station_mark), int'(got.station_mark));
            check_field("branch_seen", int'(want.branch_seen), int'(got.branch_seen));
            check_field("all_white", int'(want.all_white), int'(got.all_white));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // bounds still at reset: span is negative on every sensor
   task automatic test_after_reset();
      send_item(OP_MEASURE, {SENSOR_COUNT{12'd2048}}, 1'b1);
      send_item(OP_MEASURE, '1, 1'b0);
      send_item(OP_UNUSED, '1, 1'b1);
      wait_idle();
   endtask

   task automatic test_full_span();
      frame_type f;
      send_item(OP_CLEAR, '0, 1'b0);
      send_item(OP_CALIBRATE, '0, 1'b0);
      send_item(OP_CALIBRATE, '1, 1'b1);
      send_item(OP_MEASURE, '0, 1'b0);
      send_item(OP_MEASURE, '0, 1'b1);
      send_item(OP_MEASURE, '1, 1'b0);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         f = '0;
         f[i] = '1;
         send_item(OP_MEASURE, f, i[0]);
      end
      f = '0;
      f[0] = '1;
      f[1] = '1;
      f[2] = '1;
      send_item(OP_MEASURE, f, 1'b0);
      f = '0;
      f[1] = '1;
      f[2] = '1;
      f[3] = '1;
      send_item(OP_MEASURE, f, 1'b1);
      f = '0;
      f[0] = '1;
      f[4] = '1;
      send_item(OP_MEASURE, f, 1'b0);
      wait_idle();
   endtask

   // one calibration sample leaves low equal to high, so the divisor is 1
   task automatic test_zero_span();
      frame_type f;
      for (int i = 0; i < SENSOR_COUNT; i++) f[i] = sample_type'(1000 + 500 * i);
      send_item(OP_CLEAR, '1, 1'b1);
      send_item(OP_CALIBRATE, f, 1'b0);
      send_item(OP_MEASURE, f, 1'b1);
      for (int i = 0; i < SENSOR_COUNT; i++) f[i] = f[i] + sample_type'(1);
      send_item(OP_MEASURE, f, 1'b0);
      send_item(OP_MEASURE, '1, 1'b0);
      send_item(OP_MEASURE, '0, 1'b1);
      send_item(OP_UNUSED, random_frame(0, SampleMax), 1'b0);
      wait_idle();
   endtask

   task automatic run_sequence();
      if ($urandom_range(99) < 15) begin
         send_item(op_type'($urandom_range(3)), random_frame(0, SampleMax),
                   1'($urandom_range(1)));
         return;
      end
      if ($urandom_range(99) < 80) send_item(OP_CLEAR, random_frame(0, SampleMax), 1'b0);
      send_item(OP_CALIBRATE, random_frame(0, 1200), 1'($urandom_range(1)));
      if ($urandom_range(99) < 90)
         send_item(OP_CALIBRATE, random_frame(2800, SampleMax), 1'($urandom_range(1)));
      repeat ($urandom_range(2))
         send_item(OP_CALIBRATE, random_frame(0, SampleMax), 1'($urandom_range(1)));
      repeat ($urandom_range(14, 3))
         send_item(OP_MEASURE, random_measure(), 1'($urandom_range(1)));
   endtask

   task automatic test_random_traffic(input int segments, input int per_segment);
      int unsigned start;
      for (int seg = 0; seg < segments; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         case (seg)
            0: set_levels(200, 300, 100, 1500);
            1: set_levels(0, 0, 0, 0);
            2: set_levels(1000, 1000, 1000, 2000);
            3: set_levels(0, 1000, 1000, 2000);
            default: set_levels($urandom_range(1000), $urandom_range(1000),
                                $urandom_range(1000), $urandom_range(2000));
         endcase
         start = items_sent;
         while (items_sent - start < per_segment) run_sequence();
         // sender holds off until every result is back
         wait_idle();
      end
   endtask

   initial begin
      clear_bounds();
      active_level_q = ACTIVE_LEVEL_RESET;
      branch_level_q = BRANCH_LEVEL_RESET;
      white_level_q = WHITE_LEVEL_RESET;
      lost_error_q = LOST_ERROR_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_full_span();
      test_zero_span();
      test_random_traffic(8, 175);
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d items over clear, calibrate, measure and unused ops; checked %0d results.",
               items_sent, results_checked);
      $display("Made %0d register writes across 8 level settings and 4 flow-control modes.",
               csr_writes);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/lspe_pkg.sv
rtl/line_sensor_position_estimator.sv
rtl/lspe_checker.sv
dv/tb.sv
